/* design/fragment_reassembly_checker_assert.svh */
// Assertion macros used by the port-level checker of the fragment reassembly checker.
`ifndef FRAGMENT_REASSEMBLY_CHECKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_CHECKER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define FRC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fragment reassembly check failed");

// Next-cycle implication, off while reset is asserted
`define FRC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fragment reassembly check failed");

// Property that must follow a cycle with reset asserted
`define FRC_ASSERT_AFTER_RESET(name, cons) \
    name: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("fragment reassembly reset check failed");

`endif

/* design/frc_pkg.sv */
// Shared types and constants of the fragment reassembly checker.
package frc_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 1024;
    localparam int HDR_BYTES            = 3;
    localparam int FLAG_FIRST_BIT       = 0;
    localparam int FLAG_LAST_BIT        = 1;

    localparam int DATA_W      = 8;
    localparam int LEN_W       = 11;
    localparam int RD_ADDR_W   = 10;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;
    localparam int M_TDATA_PAD = M_TDATA_W - LEN_W - DATA_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_COMPLETE   = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_BAD        = 3'd2,
        ST_INACTIVE   = 3'd3,
        ST_TOO_LARGE  = 3'd4,
        ST_READ       = 3'd5
    } status_t;

    typedef enum logic {
        REQ_FRAGMENT = 1'b0,
        REQ_READ     = 1'b1
    } req_t;

    // One result as it leaves the tracker
    typedef struct packed {
        logic             is_read;
        logic             addr_ok;
        status_t          status;
        logic [LEN_W-1:0] length;
    } frc_res_t;

endpackage

/* design/frc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module frc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read, read data registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/frc_tracker.sv */
// Fragment header parsing, message tracking state and buffer access control.
module frc_tracker import frc_pkg::*; #(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic                            req_type,
    input  logic [DATA_W-1:0]               data_byte,
    input  logic                            frame_end,
    input  logic [RD_ADDR_W-1:0]            read_addr,
    output logic                            res_valid,
    output frc_res_t                        res,
    output logic                            ram_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] ram_wr_addr,
    output logic [DATA_W-1:0]               ram_wr_data,
    output logic                            ram_rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] ram_rd_addr
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int CNT_CAP = BUFFER_DEPTH + HDR_BYTES + 1;
    localparam int CW      = $clog2(CNT_CAP + 1);
    localparam int LW      = $clog2(BUFFER_DEPTH + 1);
    localparam int SW      = CW + 1;

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [LW-1:0]     committed_reg, committed_next;
    logic [DATA_W-1:0] exp_seq_reg, exp_seq_next;
    logic [DATA_W-1:0] total_reg, total_next;
    logic              active_reg, active_next;
    logic [DATA_W-1:0] hflags_reg, hflags_next;
    logic [DATA_W-1:0] hseq_reg, hseq_next;
    logic [DATA_W-1:0] htot_reg, htot_next;

    logic              is_frag;
    logic              is_read;
    logic [DATA_W-1:0] eff_flags, eff_seq, eff_tot;
    logic              first, last, act, hdr_match, in_payload;
    logic [DATA_W-1:0] exp_seq, exp_tot;
    logic [LW-1:0]     base;
    logic [SW-1:0]     wr_pos, chunk, msg_len;
    logic [CW-1:0]     cnt_inc;

    assign is_read = accept && (req_type == REQ_READ);
    assign is_frag = accept && (req_type == REQ_FRAGMENT);

    // Header fields with the current beat forwarded
    assign eff_flags = (cnt_reg == CW'(0)) ? data_byte : hflags_reg;
    assign eff_seq   = (cnt_reg == CW'(1)) ? data_byte : hseq_reg;
    assign eff_tot   = (cnt_reg == CW'(2)) ? data_byte : htot_reg;

    // Header check, with a FIRST fragment restarting the message
    assign first     = eff_flags[FLAG_FIRST_BIT];
    assign last      = eff_flags[FLAG_LAST_BIT];
    assign act       = first || active_reg;
    assign exp_seq   = first ? '0 : exp_seq_reg;
    assign exp_tot   = first ? eff_tot : total_reg;
    assign base      = first ? '0 : committed_reg;
    assign hdr_match = (eff_seq == exp_seq) && (eff_tot == exp_tot);

    // Speculative payload write after the committed length
    assign in_payload  = cnt_reg >= CW'(HDR_BYTES);
    assign wr_pos      = SW'(base) + SW'(cnt_reg) - SW'(HDR_BYTES);
    assign ram_wr_en   = is_frag && in_payload && act && hdr_match
                         && (wr_pos < SW'(BUFFER_DEPTH));
    assign ram_wr_addr = wr_pos[AW-1:0];
    assign ram_wr_data = data_byte;

    // Read port of the buffer
    assign ram_rd_en   = is_read;
    assign ram_rd_addr = AW'(read_addr);

    // Saturating byte count and fragment length
    assign cnt_inc = (cnt_reg == CW'(CNT_CAP)) ? cnt_reg : cnt_reg + CW'(1);
    assign chunk   = SW'(cnt_inc) - SW'(HDR_BYTES);
    assign msg_len = SW'(base) + chunk;

    // Next tracking state and the result of this beat
    always_comb begin
        cnt_next       = cnt_reg;
        committed_next = committed_reg;
        exp_seq_next   = exp_seq_reg;
        total_next     = total_reg;
        active_next    = active_reg;
        hflags_next    = hflags_reg;
        hseq_next      = hseq_reg;
        htot_next      = htot_reg;
        res_valid      = 1'b0;
        res.is_read    = 1'b0;
        res.addr_ok    = 1'b0;
        res.status     = ST_BAD;
        res.length     = '0;

        if (is_read) begin
            res_valid   = 1'b1;
            res.is_read = 1'b1;
            res.addr_ok = 32'(read_addr) < 32'(BUFFER_DEPTH);
            res.status  = ST_READ;
            res.length  = LEN_W'(committed_reg);
        end else if (is_frag) begin
            hflags_next = eff_flags;
            hseq_next   = eff_seq;
            htot_next   = eff_tot;
            cnt_next    = cnt_inc;
            if (frame_end) begin
                cnt_next  = '0;
                res_valid = 1'b1;
                if (cnt_inc < CW'(HDR_BYTES)) begin
                    res.status = ST_BAD;
                end else if (!act) begin
                    res.status = ST_INACTIVE;
                end else if (!hdr_match) begin
                    res.status = ST_BAD;
                end else if (msg_len > SW'(BUFFER_DEPTH)) begin
                    res.status = ST_TOO_LARGE;
                end else if (last) begin
                    res.status = ST_COMPLETE;
                    res.length = LEN_W'(msg_len);
                end else begin
                    res.status = ST_INCOMPLETE;
                    res.length = LEN_W'(msg_len);
                end
                // Keep the message only on an incomplete fragment, drop it otherwise
                if (res.status == ST_INCOMPLETE) begin
                    active_next    = 1'b1;
                    total_next     = exp_tot;
                    exp_seq_next   = exp_seq + DATA_W'(1);
                    committed_next = LW'(msg_len);
                end else begin
                    active_next    = 1'b0;
                    total_next     = '0;
                    exp_seq_next   = '0;
                    committed_next = '0;
                end
            end
        end
    end

    // Tracking registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            committed_reg <= '0;
            exp_seq_reg   <= '0;
            total_reg     <= '0;
            active_reg    <= 1'b0;
            hflags_reg    <= '0;
            hseq_reg      <= '0;
            htot_reg      <= '0;
        end else begin
            cnt_reg       <= cnt_next;
            committed_reg <= committed_next;
            exp_seq_reg   <= exp_seq_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            hflags_reg    <= hflags_next;
            hseq_reg      <= hseq_next;
            htot_reg      <= htot_next;
        end
    end

endmodule

/* design/frc_out_pipe.sv */
// Pending result stage and output register of the fragment reassembly checker.
module frc_out_pipe import frc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  frc_res_t          res,
    input  logic [DATA_W-1:0] ram_rd_data,
    input  logic              m_ready,
    output logic              in_ready,
    output logic              m_valid,
    output status_t           m_status,
    output logic [LEN_W-1:0]  m_length,
    output logic [DATA_W-1:0] m_read_data
);

    logic              pend_valid_reg;
    frc_res_t          pend_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_ready;

    // Advance when the next stage is empty or drains this cycle
    assign out_ready = !out_valid_reg || m_ready;
    assign in_ready  = !pend_valid_reg || out_ready;

    // Hold the result while the buffer read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (in_ready) begin
            pend_valid_reg <= res_valid;
            pend_reg       <= res;
        end
    end

    // Output register, merged with the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg  <= pend_valid_reg;
            out_status_reg <= pend_reg.status;
            out_length_reg <= pend_reg.length;
            out_data_reg   <= (pend_reg.is_read && pend_reg.addr_ok) ? ram_rd_data : '0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_length    = out_length_reg;
    assign m_read_data = out_data_reg;

endmodule

/* design/fragment_reassembly_checker.sv */
// Top level of the fragment reassembly checker.
// Takes one beat per clock: a fragment byte (tuser 0) or a buffer read (tuser 1), with tlast
// on the last byte of each fragment. Each fragment end and each read gives one result beat
// through the pending stage and the output register; a fragment byte without tlast gives
// none. The rate is one beat per cycle, set by the single tracker pass and one buffer write
// or read per beat; s_tready drops only while both the pending stage and the output register
// hold results that m_tready has not taken. The reassembly buffer is a BUFFER_DEPTH byte RAM
// with one write and one registered read port and needs no clearing pass after reset; reading
// a position that was never written returns an undefined byte.
module fragment_reassembly_checker import frc_pkg::*; #(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte [7:0], read_addr [17:8], zero pad
    input  logic                 s_tuser,   // req_type
    input  logic                 s_tlast,   // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // message_length [10:0], read_data [18:11], zero pad
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic              accept;
    logic              res_valid;
    frc_res_t          res;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    status_t           out_status;
    logic [LEN_W-1:0]  out_length;
    logic [DATA_W-1:0] out_read_data;

    assign accept = s_tvalid && s_tready;

    // Header checks and message state
    frc_tracker #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .req_type    (s_tuser),
        .data_byte   (s_tdata[DATA_W-1:0]),
        .frame_end   (s_tlast),
        .read_addr   (s_tdata[DATA_W +: RD_ADDR_W]),
        .res_valid   (res_valid),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    // Reassembly buffer
    frc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result staging toward the master side
    frc_out_pipe u_out_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_valid   (res_valid),
        .res         (res),
        .ram_rd_data (ram_rd_data),
        .m_ready     (m_tready),
        .in_ready    (s_tready),
        .m_valid     (m_tvalid),
        .m_status    (out_status),
        .m_length    (out_length),
        .m_read_data (out_read_data)
    );

    // Pack the result beat
    assign m_tdata = {{M_TDATA_PAD{1'b0}}, out_read_data, out_length};
    assign m_tuser = out_status;

endmodule

/* design/frc_checker.sv */
// Port-level assertions of the fragment reassembly checker and their bind.
`include "fragment_reassembly_checker_assert.svh"

module frc_checker import frc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    logic [LEN_W-1:0]  res_len;
    logic [DATA_W-1:0] res_rdata;
    logic              res_err;

    // Split the result beat into its fields
    assign res_len   = m_tdata[LEN_W-1:0];
    assign res_rdata = m_tdata[LEN_W +: DATA_W];
    assign res_err   = (m_tuser == ST_BAD) || (m_tuser == ST_INACTIVE)
                       || (m_tuser == ST_TOO_LARGE);

    // A stalled result beat holds
    `FRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // Only read replies carry buffer data
    `FRC_ASSERT_NOW(a_data_only_on_read, m_tvalid && (m_tuser != ST_READ), res_rdata == '0)

    // Error results report zero length
    `FRC_ASSERT_NOW(a_error_zero_len, m_tvalid && res_err, res_len == '0)

    // No result beat right after reset
    `FRC_ASSERT_AFTER_RESET(a_reset_empty, !m_tvalid)

endmodule

bind fragment_reassembly_checker frc_checker u_frc_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the fragment reassembly checker: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module testbench;
    import frc_pkg::*;

    localparam int DEPTH       = DEFAULT_BUFFER_DEPTH;
    localparam int COUNT_CAP   = DEPTH + HDR_BYTES + 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_PER_PH = 150;

    // One input beat and one result beat, field by field
    typedef struct {
        req_t             kind;
        logic [7:0]       dbyte;
        logic             fend;
        logic [9:0]       addr;
    } beat_t;

    typedef struct {
        status_t          status;
        logic [LEN_W-1:0] length;
        logic [7:0]       rdata;
    } report_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    beat_t   beats_to_send[$];
    report_t pending_reports[$];
    beat_t   on_bus;
    report_t want;
    int      src_idle_pct = 0;
    int      snk_idle_pct = 0;
    int      n_errors     = 0;
    int      n_queued     = 0;
    int      cycle_count  = 0;

    // Predicted reassembly state
    logic [7:0]  store_mem [DEPTH];
    int unsigned committed;
    logic [7:0]  exp_seq;
    logic [7:0]  msg_total;
    bit          msg_active;
    int unsigned byte_cnt;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_seq;
    logic [7:0]  hdr_total;

    fragment_reassembly_checker #(.BUFFER_DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_tracking();
        committed  = 0;
        exp_seq    = 8'd0;
        msg_total  = 8'd0;
        msg_active = 1'b0;
    endfunction

    // Header checks with FIRST applied; base is where this fragment's payload lands
    function automatic bit header_passes(output int unsigned base, output status_t why);
        bit         first;
        logic [7:0] seq_want;
        logic [7:0] tot_want;
        first    = hdr_flags[FLAG_FIRST_BIT];
        seq_want = first ? 8'd0 : exp_seq;
        tot_want = first ? hdr_total : msg_total;
        base     = first ? 0 : committed;
        why      = ST_BAD;
        if (!(first || msg_active)) begin
            why = ST_INACTIVE;
            return 1'b0;
        end
        return (hdr_seq == seq_want) && (hdr_total == tot_want);
    endfunction

    // Advance the predicted state by one accepted beat; queue the report it causes
    function automatic void reassemble_beat(beat_t b);
        int unsigned idx;
        int unsigned len;
        int unsigned chunk;
        int unsigned base;
        status_t     why;
        report_t     r;
        r.length = '0;
        r.rdata  = '0;
        if (b.kind == REQ_READ) begin
            r.status = ST_READ;
            r.length = LEN_W'(committed);
            r.rdata  = store_mem[b.addr];
            pending_reports.push_back(r);
            return;
        end
        idx = byte_cnt;
        if (idx == 0)
            hdr_flags = b.dbyte;
        else if (idx == 1)
            hdr_seq = b.dbyte;
        else if (idx == 2)
            hdr_total = b.dbyte;
        else if (header_passes(base, why) && base + idx - HDR_BYTES < DEPTH)
            store_mem[base + idx - HDR_BYTES] = b.dbyte;
        byte_cnt = (idx + 1 < COUNT_CAP) ? idx + 1 : COUNT_CAP;
        if (!b.fend)
            return;

        len      = byte_cnt;
        byte_cnt = 0;
        if (len < HDR_BYTES) begin
            clear_tracking();
            r.status = ST_BAD;
        end else if (!header_passes(base, why)) begin
            clear_tracking();
            r.status = why;
        end else begin
            chunk = len - HDR_BYTES;
            if (base + chunk > DEPTH) begin
                clear_tracking();
                r.status = ST_TOO_LARGE;
            end else if (hdr_flags[FLAG_LAST_BIT]) begin
                clear_tracking();
                r.status = ST_COMPLETE;
                r.length = LEN_W'(base + chunk);
            end else begin
                if (hdr_flags[FLAG_FIRST_BIT]) begin
                    msg_active = 1'b1;
                    msg_total  = hdr_total;
                    exp_seq    = 8'd0;
                end
                committed = base + chunk;
                exp_seq   = exp_seq + 8'd1;
                r.status  = ST_INCOMPLETE;
                r.length  = LEN_W'(committed);
            end
        end
        pending_reports.push_back(r);
    endfunction

    task automatic queue_read(input logic [9:0] addr);
        beat_t b;
        b.kind  = REQ_READ;
        b.dbyte = 8'($urandom);
        b.fend  = 1'($urandom);
        b.addr  = addr;
        beats_to_send.push_back(b);
        n_queued++;
    endtask

    // Queue one fragment of nbytes beats: header bytes first, random payload, reads mixed in
    task automatic add_frag(input logic [7:0] flags, input logic [7:0] seq,
                            input logic [7:0] tot, input int nbytes, input int read_pct);
        beat_t b;
        for (int i = 0; i < nbytes; i++) begin
            if (read_pct > 0 && $urandom_range(99) < read_pct)
                queue_read(10'($urandom));
            b.kind  = REQ_FRAGMENT;
            b.dbyte = (i == 0) ? flags : (i == 1) ? seq : (i == 2) ? tot : 8'($urandom);
            b.fend  = (i == nbytes - 1);
            b.addr  = 10'($urandom);
            beats_to_send.push_back(b);
            n_queued++;
        end
    endtask

    // Driver: predict on each accepted beat, then present the next one or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                reassemble_beat(on_bus);
            if (!s_tvalid || s_tready) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_bus = beats_to_send.pop_front();
                    s_tdata  <= {{(S_TDATA_W - DATA_W - RD_ADDR_W){1'b0}}, on_bus.addr,
                                 on_bus.dbyte};
                    s_tuser  <= on_bus.kind;
                    s_tlast  <= on_bus.fend;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result beat: status %0d length %0d", m_tuser,
                           m_tdata[LEN_W-1:0]);
                    n_errors++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        n_errors++;
                    end
                    if (m_tdata[LEN_W-1:0] !== want.length) begin
                        $error("message_length: expected %0d, actual %0d", want.length,
                               m_tdata[LEN_W-1:0]);
                        n_errors++;
                    end
                    if (m_tdata[LEN_W+DATA_W-1:LEN_W] !== want.rdata) begin
                        $error("read_data: expected %0d, actual %0d", want.rdata,
                               m_tdata[LEN_W+DATA_W-1:LEN_W]);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int         target;
        int         pick;
        int         nfr;
        int         npay;
        int         c;
        logic [7:0] flags;
        logic [7:0] seq;
        logic [7:0] tot;

        clear_tracking();
        byte_cnt  = 0;
        hdr_flags = 8'd0;
        hdr_seq   = 8'd0;
        hdr_total = 8'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 86 : 0;
            snk_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 30 : 0;

            if (ph == 0) begin
                // Short fragments, no active message, header mismatches, empty complete
                add_frag(8'h01, 8'h00, 8'h00, 1, 0);
                add_frag(8'h01, 8'h00, 8'h00, 2, 0);
                add_frag(8'h00, 8'h00, 8'h00, 3, 0);
                add_frag(8'hFD, 8'h00, 8'hFF, 5, 0);
                add_frag(8'h00, 8'h01, 8'hFE, 4, 0);
                add_frag(8'h01, 8'h00, 8'h03, 4, 0);
                add_frag(8'h00, 8'h02, 8'h03, 4, 0);
                add_frag(8'h03, 8'h00, 8'h00, 3, 0);
                add_frag(8'h01, 8'h01, 8'h07, 6, 0);
                add_frag(8'h02, 8'h00, 8'h00, 4, 0);
                // Fill the whole buffer by overflowing it from a nonzero base,
                // with the byte counter saturated in the oversized fragment
                add_frag(8'h01, 8'h00, 8'h05, 3 + 1, 0);
                add_frag(8'h00, 8'h01, 8'h05, 3 + 1026, 0);
                // Reads at the address extremes and at alternating bit patterns
                queue_read(10'h000);
                queue_read(10'h3FF);
                queue_read(10'h2AA);
                queue_read(10'h155);
            end

            // Mostly well-formed messages with random content, mixed with reads and noise
            target = n_queued + RAND_PER_PH;
            while (n_queued < target) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    nfr = $urandom_range(1, 4);
                    tot = 8'($urandom);
                    for (int f = 0; f < nfr; f++) begin
                        flags = {8'($urandom) & 8'hFC};
                        flags[FLAG_FIRST_BIT] = (f == 0);
                        flags[FLAG_LAST_BIT]  = (f == nfr - 1);
                        seq = 8'(f);
                        c = $urandom_range(99);
                        if (c < 4)
                            seq[$urandom_range(7)] ^= 1'b1;
                        else if (c < 8)
                            tot[$urandom_range(7)] ^= 1'b1;
                        else if (c < 11)
                            flags[FLAG_FIRST_BIT] ^= 1'b1;
                        npay = ($urandom_range(99) < 90) ? $urandom_range(0, 12)
                                                         : $urandom_range(13, 80);
                        add_frag(flags, seq, tot, HDR_BYTES + npay, 5);
                    end
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 3)) queue_read(10'($urandom));
                end else begin
                    add_frag(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom),
                             $urandom_range(1, 8), 0);
                end
            end

            while (beats_to_send.size() != 0 || s_tvalid)
                @(posedge aclk);
        end

        // Drain the remaining results, then allow for the pipeline
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/frc_pkg.sv
design/frc_ram.sv
design/frc_tracker.sv
design/frc_out_pipe.sv
design/fragment_reassembly_checker.sv
design/frc_checker.sv
tb/testbench.sv
